### hdl/fkht_pkg.sv
// ----------------------------------------------------------------------------
// Flow key hash table package
// Shared types, sizes, codes and hash constants of the flow table.
// ----------------------------------------------------------------------------
package fkht_pkg;

  // Table geometry.
  localparam int unsigned TABLE_SLOTS = 1024;
  localparam int unsigned SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int unsigned CNT_W       = SLOT_W + 1;
  localparam int unsigned VALUE_COUNT = 256;
  localparam int unsigned VALUE_W     = 8;

  // MurmurHash3 x86_32 constants.
  localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2 = 32'h1b873593;
  localparam logic [31:0] MM_E  = 32'he6546b64;
  localparam logic [31:0] MM_F1 = 32'h85ebca6b;
  localparam logic [31:0] MM_F2 = 32'hc2b2ae35;
  localparam logic [31:0] MM_LEN = 32'd13;

  typedef enum logic [1:0] {
    OP_ADD        = 2'd0,
    OP_GET        = 2'd1,
    OP_REMOVE_KEY = 2'd2,
    OP_REMOVE_VAL = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_ABSENT    = 3'd3,
    ST_UNMAPPED  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PRB_RD,
    S_PRB_CHK,
    S_MAP_RD,
    S_MAP_CHK,
    S_VAL_CHK,
    S_SH_RD,
    S_SH_CHK,
    S_SH_END,
    S_DONE
  } fsm_e;

  typedef struct packed {
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [7:0]  pr;
  } key_t;

  typedef struct packed {
    logic               occ;
    logic [31:0]        hash;
    key_t               key;
    logic [VALUE_W-1:0] value;
  } slot_ent_t;

  localparam int unsigned ENT_W = $bits(slot_ent_t);

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

endpackage

### hdl/fkht_ram.sv
// ----------------------------------------------------------------------------
// Flow table RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fkht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### hdl/fkht_hash.sv
// ----------------------------------------------------------------------------
// Flow key hash unit
// MurmurHash3 x86_32 over the 13 key bytes, with a single shared multiplier.
// ----------------------------------------------------------------------------
module fkht_hash (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [31:0]   seed_i,
  input  fkht_pkg::key_t key_i,
  output logic          done_o,
  output logic [31:0]   hash_o
);
  import fkht_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [1:0]  blk_q;
  logic [1:0]  sub_q;
  logic [31:0] h_q;
  logic [31:0] k_q;
  logic [31:0] blk;
  logic [31:0] hx;
  logic [31:0] tail0;
  logic [31:0] tail;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] prod;

  // Select the 32-bit block of the key; the last holds the protocol byte.
  always_comb begin
    case (blk_q)
      2'd0:    blk = key_i.sa;
      2'd1:    blk = key_i.da;
      2'd2:    blk = {key_i.dp, key_i.sp};
      default: blk = {24'd0, key_i.pr};
    endcase
  end

  // Shared multiplier and its operand selection.
  always_comb begin
    hx    = rotl32(h_q ^ k_q, 13);
    tail0 = h_q ^ k_q ^ MM_LEN;
    tail  = tail0 ^ (tail0 >> 16);
    case (sub_q)
      2'd0:    begin mul_a = blk;                  mul_b = MM_C1; end
      2'd1:    begin mul_a = rotl32(k_q, 15);      mul_b = MM_C2; end
      2'd2:    begin mul_a = tail;                 mul_b = MM_F1; end
      default: begin mul_a = h_q ^ (h_q >> 13);    mul_b = MM_F2; end
    endcase
    prod = mul_a * mul_b;
  end

  // Step sequencer: three steps per block, then the finalization.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      blk_q  <= 2'd0;
      sub_q  <= 2'd0;
      h_q    <= '0;
      k_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        blk_q  <= 2'd0;
        sub_q  <= 2'd0;
        h_q    <= seed_i;
      end else if (busy_q) begin
        case (sub_q)
          2'd0: begin
            k_q   <= prod;
            sub_q <= 2'd1;
          end
          2'd1: begin
            k_q   <= prod;
            sub_q <= 2'd2;
          end
          2'd2: begin
            if (blk_q != 2'd3) begin
              h_q   <= (hx << 2) + hx + MM_E;
              blk_q <= blk_q + 2'd1;
              sub_q <= 2'd0;
            end else begin
              h_q   <= prod;
              sub_q <= 2'd3;
            end
          end
          default: begin
            h_q    <= prod;
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        endcase
      end
    end
  end

  assign done_o = done_q;
  assign hash_o = h_q ^ (h_q >> 16);

endmodule

### hdl/flow_key_hash_table_unit.sv
// From acceptance, add, get and remove by key first hash the key, then read and check
// each probed slot in turn, and then load the result register. A removal then walks
// the backward-shift chain, reading and checking each slot up to and including the free
// slot that ends it, and frees the last hole. Remove by value reads the map and the slot
// before the chain; a full-table add or an unmapped value goes straight to the result.
// One transaction at a time. After reset a clearing pass empties the slot RAM.
// ----------------------------------------------------------------------------
// Flow key hash table unit
// Open-addressing flow table with linear probing, backward-shift removal and
// a value-to-slot reverse map.
// ----------------------------------------------------------------------------
module flow_key_hash_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  input  logic [7:0]  protocol_i,
  input  logic [7:0]  flow_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  found_value_o,
  output logic [31:0] out_src_addr_o,
  output logic [31:0] out_dst_addr_o,
  output logic [15:0] out_src_port_o,
  output logic [15:0] out_dst_port_o,
  output logic [7:0]  out_protocol_o
);
  import fkht_pkg::*;

  fsm_e                   state_q, state_d;
  op_e                    op_q;
  key_t                   key_q;
  logic [VALUE_W-1:0]     val_q;
  logic [31:0]            seed_q;
  logic [31:0]            h_q;
  logic [SLOT_W-1:0]      idx_q;
  logic [SLOT_W-1:0]      hole_q;
  logic [CNT_W-1:0]       n_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [SLOT_W-1:0]      clr_q;
  status_e                st_q;
  logic [VALUE_W-1:0]     fv_q;
  key_t                   okey_q;
  logic [VALUE_COUNT-1:0] vld_q;
  logic                   out_valid_q;
  status_e                out_st_q;
  logic [VALUE_W-1:0]     out_fv_q;
  key_t                   out_key_q;

  logic                   accept;
  logic                   hash_start;
  logic                   hash_done;
  logic [31:0]            hash_val;
  key_t                   in_key;
  logic                   s_we, s_re;
  logic [SLOT_W-1:0]      s_waddr, s_raddr;
  slot_ent_t              s_wdata, s_rdata;
  logic                   m_we, m_re;
  logic [VALUE_W-1:0]     m_waddr, m_raddr;
  logic [SLOT_W-1:0]      m_wdata, m_rdata;
  logic                   hit;
  logic                   probe_last;
  logic                   sh_last;
  logic [SLOT_W-1:0]      home;
  logic                   move;
  logic                   out_load;

  assign in_key = '{sa: src_addr_i, da: dst_addr_i, sp: src_port_i,
                    dp: dst_port_i, pr: protocol_i};
  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  // Decisions on the slot read data.
  always_comb begin
    hit        = s_rdata.occ && (s_rdata.hash == h_q) && (s_rdata.key == key_q);
    probe_last = (n_q + CNT_W'(1)) == CNT_W'(TABLE_SLOTS);
    sh_last    = probe_last;
    home       = s_rdata.hash[SLOT_W-1:0];
    move       = s_rdata.occ && (idx_q != home) &&
                 (SLOT_W'(idx_q - home) > SLOT_W'(hole_q - home));
  end

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == SLOT_W'(TABLE_SLOTS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (op_e'(operation_i) == OP_REMOVE_VAL) begin
            state_d = vld_q[flow_value_i] ? S_MAP_RD : S_DONE;
          end else if (op_e'(operation_i) == OP_ADD &&
                       cnt_q >= CNT_W'(TABLE_SLOTS)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hash_done) state_d = S_PRB_RD;
      end
      S_PRB_RD: state_d = S_PRB_CHK;
      S_PRB_CHK: begin
        if (!s_rdata.occ) begin
          state_d = S_DONE;
        end else if (hit) begin
          state_d = (op_q == OP_REMOVE_KEY) ? S_SH_RD : S_DONE;
        end else if (probe_last) begin
          state_d = S_DONE;
        end else begin
          state_d = S_PRB_RD;
        end
      end
      S_MAP_RD:  state_d = S_MAP_CHK;
      S_MAP_CHK: state_d = S_VAL_CHK;
      S_VAL_CHK: state_d = s_rdata.occ ? S_SH_RD : S_DONE;
      S_SH_RD:   state_d = S_SH_CHK;
      S_SH_CHK: begin
        if (!s_rdata.occ || sh_last) state_d = S_SH_END;
        else state_d = S_SH_RD;
      end
      S_SH_END: state_d = S_DONE;
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // Memory and hash control outputs.
  always_comb begin
    hash_start = 1'b0;
    s_we    = 1'b0;
    s_waddr = hole_q;
    s_wdata = '0;
    s_re    = 1'b0;
    s_raddr = idx_q;
    m_we    = 1'b0;
    m_waddr = val_q;
    m_wdata = idx_q;
    m_re    = 1'b0;
    m_raddr = val_q;
    case (state_q)
      S_CLEAR: begin
        s_we    = 1'b1;
        s_waddr = clr_q;
      end
      S_IDLE: begin
        hash_start = accept;
      end
      S_PRB_RD, S_SH_RD: begin
        s_re = 1'b1;
      end
      S_PRB_CHK: begin
        if (!s_rdata.occ && op_q == OP_ADD) begin
          s_we    = 1'b1;
          s_waddr = idx_q;
          s_wdata = '{occ: 1'b1, hash: h_q, key: key_q, value: val_q};
          m_we    = 1'b1;
        end
      end
      S_MAP_RD: begin
        m_re = 1'b1;
      end
      S_MAP_CHK: begin
        s_re    = 1'b1;
        s_raddr = m_rdata;
      end
      S_SH_CHK: begin
        if (move) begin
          s_we    = 1'b1;
          s_wdata = s_rdata;
          m_we    = 1'b1;
          m_waddr = s_rdata.value;
          m_wdata = hole_q;
        end
      end
      S_SH_END: begin
        s_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Datapath and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
      vld_q   <= '0;
      seed_q  <= '0;
      op_q    <= OP_ADD;
      key_q   <= '0;
      val_q   <= '0;
      h_q     <= '0;
      idx_q   <= '0;
      hole_q  <= '0;
      n_q     <= '0;
      st_q    <= ST_OK;
      fv_q    <= '0;
      okey_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) seed_q <= cfg_wdata_i;
      case (state_q)
        S_CLEAR: clr_q <= clr_q + SLOT_W'(1);
        S_IDLE: begin
          if (accept) begin
            op_q   <= op_e'(operation_i);
            key_q  <= in_key;
            val_q  <= flow_value_i;
            fv_q   <= '0;
            okey_q <= '0;
            st_q   <= ST_OK;
            if (op_e'(operation_i) == OP_REMOVE_VAL) begin
              if (!vld_q[flow_value_i]) st_q <= ST_UNMAPPED;
            end else if (op_e'(operation_i) == OP_ADD &&
                         cnt_q >= CNT_W'(TABLE_SLOTS)) begin
              st_q <= ST_FULL;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            h_q   <= hash_val;
            idx_q <= hash_val[SLOT_W-1:0];
            n_q   <= '0;
          end
        end
        S_PRB_CHK: begin
          if (!s_rdata.occ) begin
            if (op_q == OP_ADD) begin
              cnt_q        <= cnt_q + CNT_W'(1);
              vld_q[val_q] <= 1'b1;
            end else begin
              st_q <= ST_ABSENT;
            end
          end else if (hit) begin
            if (op_q == OP_ADD) begin
              st_q <= ST_DUPLICATE;
            end else begin
              fv_q <= s_rdata.value;
              if (op_q == OP_REMOVE_KEY) begin
                cnt_q                <= cnt_q - CNT_W'(1);
                vld_q[s_rdata.value] <= 1'b0;
                hole_q               <= idx_q;
                idx_q                <= idx_q + SLOT_W'(1);
                n_q                  <= CNT_W'(1);
              end
            end
          end else begin
            if (probe_last) st_q <= ST_ABSENT;
            idx_q <= idx_q + SLOT_W'(1);
            n_q   <= n_q + CNT_W'(1);
          end
        end
        S_MAP_CHK: idx_q <= m_rdata;
        S_VAL_CHK: begin
          if (!s_rdata.occ) begin
            st_q <= ST_UNMAPPED;
          end else begin
            okey_q               <= s_rdata.key;
            cnt_q                <= cnt_q - CNT_W'(1);
            vld_q[s_rdata.value] <= 1'b0;
            hole_q               <= idx_q;
            idx_q                <= idx_q + SLOT_W'(1);
            n_q                  <= CNT_W'(1);
          end
        end
        S_SH_CHK: begin
          if (move) begin
            vld_q[s_rdata.value] <= 1'b1;
            hole_q               <= idx_q;
          end
          idx_q <= idx_q + SLOT_W'(1);
          n_q   <= n_q + CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: a finished result waits here for the consumer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_st_q    <= ST_OK;
      out_fv_q    <= '0;
      out_key_q   <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_st_q    <= st_q;
        out_fv_q    <= fv_q;
        out_key_q   <= okey_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign found_value_o  = out_fv_q;
  assign out_src_addr_o = out_key_q.sa;
  assign out_dst_addr_o = out_key_q.da;
  assign out_src_port_o = out_key_q.sp;
  assign out_dst_port_o = out_key_q.dp;
  assign out_protocol_o = out_key_q.pr;

  fkht_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .seed_i  (seed_q),
    .key_i   (key_q),
    .done_o  (hash_done),
    .hash_o  (hash_val)
  );

  fkht_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  fkht_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (VALUE_COUNT)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (m_wdata),
    .re_i    (m_re),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

endmodule

### hdl/fkht_checker.sv
// ----------------------------------------------------------------------------
// Flow key hash table checker
// Port-level properties of the flow table unit, attached by bind.
// ----------------------------------------------------------------------------
module fkht_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [7:0]  found_value_o,
  input logic [31:0] out_src_addr_o
);
  import fkht_pkg::*;

  // A waiting result holds its status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result changed while stalled");

  // Status codes stay within the defined set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_FULL ||
                     status_o == ST_DUPLICATE || status_o == ST_ABSENT ||
                     status_o == ST_UNMAPPED))
    else $error("undefined status code");

  // A failed transaction returns no value and no key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> found_value_o == 8'd0 && out_src_addr_o == 32'd0)
    else $error("failed transaction carries data");

  // An input accepted now is still being processed in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction accepted back to back");

endmodule

bind flow_key_hash_table_unit fkht_checker u_fkht_checker (.*);

### tb/flow_key_hash_table_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Flow key hash table unit testbench
// Drives add, get and remove operations with random gaps and stalls. A local
// copy of the flow table predicts every status and returned key or value.
// ----------------------------------------------------------------------------
module flow_key_hash_table_unit_tb;
  import fkht_pkg::*;

  typedef struct packed {
    op_e         op;
    key_t        key;
    logic [7:0]  value;
  } flow_req_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  found;
    key_t        key;
  } flow_rsp_t;

  localparam int unsigned SLOT_MASK = TABLE_SLOTS - 1;
  localparam longint      CYCLE_LIMIT = 8000000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  operation_i;
  logic [31:0] src_addr_i;
  logic [31:0] dst_addr_i;
  logic [15:0] src_port_i;
  logic [15:0] dst_port_i;
  logic [7:0]  protocol_i;
  logic [7:0]  flow_value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  status_o;
  logic [7:0]  found_value_o;
  logic [31:0] out_src_addr_o;
  logic [31:0] out_dst_addr_o;
  logic [15:0] out_src_port_o;
  logic [15:0] out_dst_port_o;
  logic [7:0]  out_protocol_o;

  flow_key_hash_table_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .src_addr_i     (src_addr_i),
    .dst_addr_i     (dst_addr_i),
    .src_port_i     (src_port_i),
    .dst_port_i     (dst_port_i),
    .protocol_i     (protocol_i),
    .flow_value_i   (flow_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .found_value_o  (found_value_o),
    .out_src_addr_o (out_src_addr_o),
    .out_dst_addr_o (out_dst_addr_o),
    .out_src_port_o (out_src_port_o),
    .out_dst_port_o (out_dst_port_o),
    .out_protocol_o (out_protocol_o)
  );

  // Shadow copy of the flow table.
  logic [31:0]  seed_q;
  logic         tbl_occ   [TABLE_SLOTS];
  logic [31:0]  tbl_hash  [TABLE_SLOTS];
  key_t         tbl_key   [TABLE_SLOTS];
  logic [7:0]   tbl_value [TABLE_SLOTS];
  logic         map_ok    [VALUE_COUNT];
  int unsigned  map_slot  [VALUE_COUNT];
  int unsigned  entries;

  flow_req_t pending_reqs[$];
  flow_rsp_t expected_rsps[$];
  key_t      live_keys[$];
  flow_req_t cur_req;
  flow_rsp_t pred_rsp;
  flow_rsp_t exp_rsp;
  flow_rsp_t act_rsp;
  int unsigned mismatches;
  int unsigned rsp_count;
  int unsigned queued_count;
  int unsigned hold_gap;
  int unsigned stall_gap;
  int unsigned full_seen;
  longint      cycles;

  function automatic logic [31:0] mix_word(input logic [31:0] k);
    logic [31:0] m;
    m = k * 32'hcc9e2d51;
    m = (m << 15) | (m >> 17);
    return m * 32'h1b873593;
  endfunction

  // MurmurHash3 over the 13 packed key bytes.
  function automatic logic [31:0] flow_hash(input key_t k);
    logic [31:0] h;
    logic [31:0] blk [3];
    blk[0] = k.sa;
    blk[1] = k.da;
    blk[2] = {k.dp, k.sp};
    h = seed_q;
    for (int i = 0; i < 3; i++) begin
      h ^= mix_word(blk[i]);
      h = (h << 13) | (h >> 19);
      h = h * 32'd5 + 32'he6546b64;
    end
    h ^= mix_word({24'd0, k.pr});
    h ^= 32'd13;
    h ^= h >> 16;
    h *= 32'h85ebca6b;
    h ^= h >> 13;
    h *= 32'hc2b2ae35;
    h ^= h >> 16;
    return h;
  endfunction

  function automatic int unsigned ring_dist(input int unsigned a, input int unsigned b);
    return (a + TABLE_SLOTS - b) & SLOT_MASK;
  endfunction

  // Free a slot and compact the probe chain behind it.
  task automatic evict_slot(input int unsigned idx);
    int unsigned hole;
    int unsigned home;
    hole = idx;
    tbl_occ[idx] = 1'b0;
    tbl_hash[idx] = '0;
    entries--;
    map_ok[tbl_value[idx]] = 1'b0;
    for (int n = 1; n < TABLE_SLOTS; n++) begin
      idx = (idx + 1) & SLOT_MASK;
      if (!tbl_occ[idx]) break;
      home = tbl_hash[idx] & SLOT_MASK;
      if (idx != home && ring_dist(idx, home) > ring_dist(hole, home)) begin
        tbl_occ[idx] = 1'b0;
        tbl_hash[hole] = tbl_hash[idx];
        tbl_value[hole] = tbl_value[idx];
        tbl_key[hole] = tbl_key[idx];
        map_slot[tbl_value[idx]] = hole;
        map_ok[tbl_value[idx]] = 1'b1;
        tbl_occ[hole] = 1'b1;
        hole = idx;
      end
    end
  endtask

  // Apply one request to the shadow table and return its response.
  task automatic apply_flow_op(input flow_req_t r, output flow_rsp_t rsp);
    logic [31:0] h;
    int unsigned slot;
    bit          hit;
    rsp = '0;
    rsp.status = ST_OK;
    case (r.op)
      OP_ADD: begin
        if (entries >= TABLE_SLOTS) begin
          rsp.status = ST_FULL;
          full_seen++;
          return;
        end
        h = flow_hash(r.key);
        slot = h & SLOT_MASK;
        for (int n = 0; n < TABLE_SLOTS && tbl_occ[slot]; n++) begin
          if (tbl_hash[slot] == h && tbl_key[slot] == r.key) begin
            rsp.status = ST_DUPLICATE;
            return;
          end
          slot = (slot + 1) & SLOT_MASK;
        end
        tbl_key[slot] = r.key;
        tbl_value[slot] = r.value;
        tbl_hash[slot] = h;
        map_slot[r.value] = slot;
        map_ok[r.value] = 1'b1;
        tbl_occ[slot] = 1'b1;
        entries++;
      end
      OP_GET, OP_REMOVE_KEY: begin
        h = flow_hash(r.key);
        slot = h & SLOT_MASK;
        hit = 1'b0;
        for (int n = 0; n < TABLE_SLOTS; n++) begin
          if (!tbl_occ[slot]) break;
          if (tbl_hash[slot] == h && tbl_key[slot] == r.key) begin
            hit = 1'b1;
            break;
          end
          slot = (slot + 1) & SLOT_MASK;
        end
        if (!hit) begin
          rsp.status = ST_ABSENT;
          return;
        end
        rsp.found = tbl_value[slot];
        if (r.op == OP_REMOVE_KEY) evict_slot(slot);
      end
      default: begin
        if (!map_ok[r.value] || !tbl_occ[map_slot[r.value]]) begin
          rsp.status = ST_UNMAPPED;
          return;
        end
        slot = map_slot[r.value];
        rsp.key = tbl_key[slot];
        evict_slot(slot);
      end
    endcase
  endtask

  function automatic key_t random_key();
    key_t k;
    k.sa = $urandom;
    k.da = $urandom;
    k.sp = 16'($urandom);
    k.dp = 16'($urandom);
    k.pr = 8'($urandom);
    return k;
  endfunction

  // Known keys are reused often so that hits, duplicates and removals occur.
  function automatic key_t pick_key();
    if (live_keys.size() > 0 && $urandom_range(0, 3) != 0)
      return live_keys[$urandom_range(0, live_keys.size() - 1)];
    return random_key();
  endfunction

  task automatic queue_req(input op_e op, input key_t k, input logic [7:0] v);
    flow_req_t r;
    r.op = op;
    r.key = k;
    r.value = v;
    pending_reqs.push_back(r);
    queued_count++;
    if (op == OP_ADD && live_keys.size() < 600) live_keys.push_back(k);
  endtask

  // One request of a random kind.
  task automatic queue_mixed();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel) inside
      [0:3]:   queue_req(OP_ADD, pick_key(), 8'($urandom));
      [4:5]:   queue_req(OP_GET, pick_key(), 8'($urandom));
      [6:7]:   queue_req(OP_REMOVE_KEY, pick_key(), 8'($urandom));
      default: queue_req(OP_REMOVE_VAL, random_key(), 8'($urandom));
    endcase
  endtask

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 4) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Wait until every queued transaction has returned, then change the seed.
  task automatic drain_and_write_seed(input logic [31:0] s);
    wait (rsp_count == queued_count);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= s;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    seed_q = s;
  endtask

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Driver: presents queued requests and holds each one until it is accepted.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      operation_i  <= '0;
      src_addr_i   <= '0;
      dst_addr_i   <= '0;
      src_port_i   <= '0;
      dst_port_i   <= '0;
      protocol_i   <= '0;
      flow_value_i <= '0;
      hold_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        apply_flow_op(cur_req, pred_rsp);
        expected_rsps.push_back(pred_rsp);
        hold_gap = pick_gap();
      end
      if (!in_valid_i || in_ready_o) begin
        if (hold_gap > 0) begin
          hold_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          in_valid_i   <= 1'b1;
          operation_i  <= cur_req.op;
          src_addr_i   <= cur_req.key.sa;
          dst_addr_i   <= cur_req.key.da;
          src_port_i   <= cur_req.key.sp;
          dst_port_i   <= cur_req.key.dp;
          protocol_i   <= cur_req.key.pr;
          flow_value_i <= cur_req.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction and applies random back-pressure.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_gap = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        act_rsp.status = status_e'(status_o);
        act_rsp.found  = found_value_o;
        act_rsp.key    = '{sa: out_src_addr_o, da: out_dst_addr_o, sp: out_src_port_o,
                           dp: out_dst_port_o, pr: out_protocol_o};
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result: status %0d found %0h key %h",
                     act_rsp.status, act_rsp.found, act_rsp.key);
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (act_rsp !== exp_rsp) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch at result %0d: expected status %0d found %0h key %h, got status %0d found %0h key %h",
                       rsp_count, exp_rsp.status, exp_rsp.found, exp_rsp.key,
                       act_rsp.status, act_rsp.found, act_rsp.key);
          end
        end
        rsp_count++;
        stall_gap = pick_gap();
      end
      if (stall_gap > 0) begin
        stall_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Cycle limit guards against a hang.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Cycle limit reached with %0d of %0d results", rsp_count, queued_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Stimulus: a mixed phase, a seed change, a fill to capacity and a mixed tail.
  initial begin
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    seed_q      = '0;
    entries     = 0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      tbl_occ[i]   = 1'b0;
      tbl_hash[i]  = '0;
      tbl_key[i]   = '0;
      tbl_value[i] = '0;
    end
    for (int i = 0; i < VALUE_COUNT; i++) begin
      map_ok[i]   = 1'b0;
      map_slot[i] = 0;
    end
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < 400; i++) queue_mixed();
    drain_and_write_seed($urandom);
    for (int i = 0; i < 1000; i++) queue_req(OP_ADD, random_key(), 8'($urandom));
    for (int i = 0; i < 150; i++) queue_mixed();

    wait (rsp_count == queued_count);
    repeat (10) @(posedge clk_i);

    $display("Ran %0d transactions of all four kinds with random gaps and output stalls,",
             rsp_count);
    $display("a seed change after a full drain, and a fill past capacity (%0d full answers).",
             full_seen);
    if (mismatches == 0 && expected_rsps.size() == 0 && rsp_count == queued_count)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
